### rtl/audio_clock_dll_tracker_core_defines.svh
// assertion macros used by the tracker core
`ifndef AUDIO_CLOCK_DLL_TRACKER_CORE_DEFINES_SVH
`define AUDIO_CLOCK_DLL_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ADTR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ADTR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adtr_pkg.sv
// shared constants, operation codes and control types of the dll tracker
package adtr_pkg;

    localparam int unsigned MAX_PERIOD_FRAMES = 4096;

    localparam int FRAMES_W = 13;
    localparam int RATE_W   = 18;
    localparam int DIV_W    = 83;
    localparam int DVS_W    = 34;
    localparam int TMP_W    = 64;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    localparam logic [29:0] NS_PER_S     = 30'd1000000000;
    localparam logic [33:0] TEN_S_NS     = 34'd10000000000;
    localparam logic [32:0] HALF_TEN_S   = 33'd5000000000;
    localparam logic [28:0] HALF_S_NS    = 29'd500000000;
    // floor(2^64 / divisor), quotient estimate is low by at most one
    localparam logic [63:0] RECIP_NS_PER_S = 64'd18446744073;
    localparam logic [63:0] RECIP_TEN_S    = 64'd1844674407;
    localparam logic signed [63:0] ERR_LIMIT_NS = 64'sd200000000;
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
    localparam logic [63:0] SQRT2_Q62    = 64'h5A827999FCEF3242;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_PDIV  = 4'd1,
        OP_GMUL  = 4'd2,
        OP_QMUL1 = 4'd3,
        OP_RMUL1 = 4'd4,
        OP_QMUL2 = 4'd5,
        OP_RMUL2 = 4'd6,
        OP_BMUL  = 4'd7,
        OP_CMUL  = 4'd8,
        OP_BEMUL = 4'd9,
        OP_XUPD  = 4'd10,
        OP_CEMUL = 4'd11
    } op_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic start;
        logic wb;
        logic load_out;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frames_zero;
        logic changed;
        logic big_err;
        logic chg_flag;
        logic unit_done;
        logic out_free;
    } ctrl_status_t;

endpackage

### rtl/adtr_if.sv
// request and result channel interfaces of the dll tracker

interface adtr_req_if;
    logic        valid;
    logic        ready;
    logic [62:0] now_ns;
    logic [12:0] frames;

    modport source (output valid, output now_ns, output frames, input ready);
    modport sink (input valid, input now_ns, input frames, output ready);
endinterface

interface adtr_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] next_time_ns;
    logic signed [63:0] next_position;
    logic [12:0]        period_frames_out;
    logic signed [31:0] slew_frames;
    logic               resynced;
    logic               period_changed;

    modport source (output valid, output next_time_ns, output next_position,
                    output period_frames_out, output slew_frames, output resynced,
                    output period_changed, input ready);
    modport sink (input valid, input next_time_ns, input next_position,
                  input period_frames_out, input slew_frames, input resynced,
                  input period_changed, output ready);
endinterface

### rtl/adtr_mul.sv
// 64x64 multiplier built from four 32x32 partial products
module adtr_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         pp_vld_reg;
    logic         done_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_shifted;

    // operand halves picked by the step count
    assign a_part     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_shifted = {64'd0, pp_reg} << {pp_sh_reg, 5'd0};

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 3'd0;
            busy_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg    <= 3'd0;
                busy_reg   <= 1'b1;
                pp_vld_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg   <= 1'b0;
                    pp_vld_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    cnt_reg    <= cnt_reg + 3'd1;
                    pp_vld_reg <= 1'b1;
                end
            end
        end
    end

    // partial product register and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            pp_reg    <= a_part * b_part;
            pp_sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

### rtl/adtr_div.sv
// restoring divider, one quotient bit per cycle
module adtr_div
    import adtr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quo,
    output logic             done
);
    localparam int CNT_W = $clog2(DIV_W);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // trial subtraction
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;
endmodule

### rtl/adtr_datapath.sv
// loop state, shared multiplier and divider, writeback and result register
module adtr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [17:0]           cfg_wdata,
    input  logic [62:0]           in_now,
    input  logic [12:0]           in_frames,
    input  adtr_pkg::ctrl_cmd_t   cmd,
    output adtr_pkg::ctrl_status_t status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic signed [63:0]    out_time,
    output logic signed [63:0]    out_pos,
    output logic [12:0]           out_period,
    output logic signed [31:0]    out_slew,
    output logic                  out_resync,
    output logic                  out_changed
);
    import adtr_pkg::*;

    logic [RATE_W-1:0]   rate_reg;
    logic [62:0]         now_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [FRAMES_W-1:0] tracked_reg;
    logic signed [63:0]  period_reg;
    logic signed [63:0]  expected_reg;
    logic [63:0]         pos_reg;
    logic [47:0]         gain_b_reg;
    logic [47:0]         gain_c_reg;
    logic signed [63:0]  e_reg;
    logic [TMP_W-1:0]    tmp_reg;
    logic [63:0]         cd_n_reg;
    logic [63:0]         cd_q_reg;
    logic [63:0]         q1_reg;
    logic signed [31:0]  slew_reg;
    logic                changed_reg;
    logic                resync_reg;
    logic                out_valid_reg;

    logic [RATE_W-1:0]   rate_eff;
    logic [FRAMES_W-1:0] frames_clamped;
    logic signed [64:0]  err_diff;
    logic signed [63:0]  err_val;
    logic [63:0]         err_abs;
    logic [63:0]         err_mag;
    logic [42:0]         n_val;
    logic                is_mul;
    logic                is_div;
    logic [63:0]         mul_a;
    logic [63:0]         mul_b;
    logic [127:0]        mul_prod;
    logic                mul_done;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVS_W-1:0]    div_divisor;
    logic [DIV_W-1:0]    div_quo;
    logic                div_done;
    logic signed [63:0]  np;
    logic signed [63:0]  now64;
    logic [63:0]         gr;
    logic signed [63:0]  gr_signed;
    logic signed [63:0]  p_new;
    logic signed [63:0]  slew64;
    logic [63:0]         cd_d;
    logic [63:0]         cd_recip;
    logic [63:0]         cd_r0;
    logic                cd_ge;
    logic [63:0]         cd_q;
    logic [63:0]         cd_r;
    logic [47:0]         ra_rate;
    logic [51:0]         q1_rate;
    logic [63:0]         next_num;
    logic [63:0]         cd_sum;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? S64_MIN : S64_MAX;
        else
            sat_add = s[63:0];
    endfunction

    // q32 to whole ns, halves rounded toward plus infinity
    function automatic logic signed [63:0] round_q32(input logic signed [63:0] x);
        logic [63:0] m;
        logic [64:0] t;
        if (!x[63])
        begin
            t = {1'b0, x} + 65'h80000000;
            round_q32 = 64'(t[64:32]);
        end
        else
        begin
            m = 64'd0 - x;
            t = {1'b0, m} + 65'h7FFFFFFF;
            round_q32 = 64'd0 - 64'(t[64:32]);
        end
    endfunction

    // input side helpers
    assign rate_eff       = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
    assign frames_clamped = (17'(in_frames) > 17'(MAX_PERIOD_FRAMES)) ?
                            FRAMES_W'(MAX_PERIOD_FRAMES) : in_frames;
    assign now64          = {1'b0, now_reg};

    // timing error, saturated on the positive side
    assign err_diff = {2'b00, now_reg} - {expected_reg[63], expected_reg};
    assign err_val  = (!err_diff[64] && err_diff[63]) ? S64_MAX : err_diff[63:0];
    assign err_abs  = err_val[63] ? (64'd0 - err_val) : err_val;
    assign err_mag  = e_reg[63] ? (64'd0 - e_reg) : e_reg;

    // status to the controller
    assign status.frames_zero = (in_frames == '0);
    assign status.changed     = (frames_reg != tracked_reg);
    assign status.big_err     = (err_val >= ERR_LIMIT_NS) || (err_val <= -ERR_LIMIT_NS);
    assign status.chg_flag    = changed_reg;
    assign status.unit_done   = mul_done | div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

    // constant division by reciprocal multiply and one correction step
    assign cd_d     = changed_reg ? 64'(TEN_S_NS) : 64'(NS_PER_S);
    assign cd_recip = changed_reg ? RECIP_TEN_S : RECIP_NS_PER_S;
    assign cd_r0    = cd_n_reg - mul_prod[63:0];
    assign cd_ge    = cd_r0 >= cd_d;
    assign cd_q     = cd_q_reg + 64'(cd_ge);
    assign cd_r     = cd_ge ? (cd_r0 - cd_d) : cd_r0;
    assign ra_rate  = cd_n_reg[29:0] * rate_eff;
    assign q1_rate  = q1_reg[33:0] * rate_eff;
    assign next_num = changed_reg ? ({cd_n_reg[45:0], 18'd0} + 64'(HALF_TEN_S))
                                  : (64'(ra_rate) + 64'(HALF_S_NS));
    assign cd_sum   = q1_reg + cd_q;

    // operand selection for the shared units
    assign n_val  = 43'(frames_reg) * 43'(NS_PER_S);
    assign is_div = (cmd.op == OP_PDIV);
    assign is_mul = (cmd.op == OP_GMUL) || (cmd.op == OP_QMUL1) || (cmd.op == OP_RMUL1) ||
                    (cmd.op == OP_QMUL2) || (cmd.op == OP_RMUL2) || (cmd.op == OP_BMUL) ||
                    (cmd.op == OP_CMUL) || (cmd.op == OP_BEMUL) || (cmd.op == OP_CEMUL);

    always_comb
    begin
        mul_a        = 64'd0;
        mul_b        = 64'd0;
        div_dividend = '0;
        div_divisor  = DVS_W'(1);
        unique case (cmd.op)
            OP_PDIV:
            begin
                div_dividend = {8'd0, n_val, 32'd0} | DIV_W'(rate_eff >> 1);
                div_divisor  = DVS_W'(rate_eff);
            end
            OP_GMUL:
            begin
                mul_a = PI_Q62;
                mul_b = period_reg;
            end
            OP_QMUL1:
            begin
                mul_a = cd_n_reg;
                mul_b = cd_recip;
            end
            OP_QMUL2:
            begin
                mul_a = next_num;
                mul_b = cd_recip;
            end
            OP_RMUL1, OP_RMUL2:
            begin
                mul_a = cd_q_reg;
                mul_b = cd_d;
            end
            OP_BMUL:
            begin
                mul_a = SQRT2_Q62;
                mul_b = tmp_reg[63:0];
            end
            OP_CMUL:
            begin
                mul_a = tmp_reg[63:0];
                mul_b = tmp_reg[63:0];
            end
            OP_BEMUL:
            begin
                mul_a = 64'(gain_b_reg);
                mul_b = err_mag;
            end
            OP_CEMUL:
            begin
                mul_a = 64'(gain_c_reg);
                mul_b = err_mag;
            end
            default:
            begin
                mul_a = 64'd0;
            end
        endcase
    end

    adtr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start & is_mul),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    adtr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start & is_div),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quo      (div_quo),
        .done     (div_done)
    );

    // writeback values
    assign np        = (|div_quo[DIV_W-1:63]) ? S64_MAX : {1'b0, div_quo[62:0]};
    assign gr        = mul_prod[79:16];
    assign gr_signed = e_reg[63] ? (64'd0 - gr) : gr;
    assign p_new     = sat_add(period_reg, gr_signed);
    assign slew64    = 64'(slew_reg);

    // loop state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_RESET;
            tracked_reg  <= '0;
            period_reg   <= '0;
            expected_reg <= '0;
            pos_reg      <= '0;
            gain_b_reg   <= '0;
            gain_c_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            if (cmd.wb)
            begin
                unique case (cmd.op)
                    OP_PDIV:
                    begin
                        period_reg <= np;
                        if (changed_reg)
                        begin
                            if (tracked_reg == '0)
                                expected_reg <= sat_add(now64, round_q32(np));
                            else
                                expected_reg <= sat_add(expected_reg, round_q32(period_reg));
                            tracked_reg <= frames_reg;
                            pos_reg     <= pos_reg + 64'(frames_reg);
                        end
                        else
                        begin
                            expected_reg <= sat_add(now64, round_q32(np));
                            pos_reg      <= pos_reg + slew64 + 64'(frames_reg);
                        end
                    end
                    OP_BMUL:
                    begin
                        gain_b_reg <= mul_prod[109:62] + 48'(mul_prod[61]);
                    end
                    OP_CMUL:
                    begin
                        gain_c_reg <= mul_prod[95:48] + 48'(mul_prod[47]);
                    end
                    OP_XUPD:
                    begin
                        expected_reg <= sat_add(expected_reg, round_q32(tmp_reg[63:0]));
                    end
                    OP_CEMUL:
                    begin
                        period_reg <= p_new[63] ? 64'sd0 : p_new;
                        pos_reg    <= pos_reg + 64'(frames_reg);
                    end
                    default:
                    begin
                        pos_reg <= pos_reg;
                    end
                endcase
            end
        end
    end

    // per-transaction working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            now_reg    <= in_now;
            frames_reg <= frames_clamped;
        end
        if (cmd.eval)
        begin
            e_reg       <= err_val;
            cd_n_reg    <= err_abs;
            changed_reg <= status.changed;
            resync_reg  <= !status.changed && status.big_err;
            slew_reg    <= '0;
        end
        if (cmd.wb)
        begin
            unique case (cmd.op)
                OP_GMUL:  cd_n_reg <= mul_prod[127:64];
                OP_QMUL1: cd_q_reg <= mul_prod[127:64];
                OP_RMUL1:
                begin
                    q1_reg   <= cd_q;
                    cd_n_reg <= cd_r;
                end
                OP_QMUL2:
                begin
                    cd_q_reg <= mul_prod[127:64];
                    cd_n_reg <= next_num;
                    q1_reg   <= changed_reg ? {q1_reg[45:0], 18'd0} : 64'(q1_rate);
                end
                OP_RMUL2:
                begin
                    if (changed_reg)
                        tmp_reg <= cd_sum;
                    else if (e_reg[63])
                        slew_reg <= (|cd_sum[63:31]) ? 32'sh80000000
                                                     : 32'd0 - cd_sum[31:0];
                    else
                        slew_reg <= (|cd_sum[63:31]) ? 32'sh7FFFFFFF : cd_sum[31:0];
                end
                OP_BEMUL: tmp_reg <= TMP_W'(sat_add(period_reg, gr_signed));
                default:  tmp_reg <= tmp_reg;
            endcase
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_time    <= expected_reg;
            out_pos     <= pos_reg;
            out_period  <= tracked_reg;
            out_slew    <= slew_reg;
            out_resync  <= resync_reg;
            out_changed <= changed_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

### rtl/adtr_ctrl.sv
// controller state machine sequencing one request through the datapath
module adtr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  adtr_pkg::ctrl_status_t status,
    output adtr_pkg::ctrl_cmd_t    cmd
);
    import adtr_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_EVAL  = 13'b0000000000010,
        S_PDIV  = 13'b0000000000100,
        S_GMUL  = 13'b0000000001000,
        S_QMUL1 = 13'b0000000010000,
        S_RMUL1 = 13'b0000000100000,
        S_QMUL2 = 13'b0000001000000,
        S_RMUL2 = 13'b0000010000000,
        S_BMUL  = 13'b0000100000000,
        S_CMUL  = 13'b0001000000000,
        S_BEMUL = 13'b0010000000000,
        S_XUPD  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after;
    logic   launched_reg;
    logic   launched_next;
    logic   unit_step;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        cmd           = '0;
        cmd.op        = OP_NONE;
        in_ready      = 1'b0;
        after         = S_OUT;
        unit_step     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (!status.frames_zero)
                        state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.changed)
                    state_next = S_PDIV;
                else if (status.big_err)
                    state_next = S_QMUL1;
                else
                    state_next = S_BEMUL;
            end
            S_PDIV:
            begin
                cmd.op    = OP_PDIV;
                unit_step = 1'b1;
                after     = status.chg_flag ? S_GMUL : S_OUT;
            end
            S_GMUL:
            begin
                cmd.op    = OP_GMUL;
                unit_step = 1'b1;
                after     = S_QMUL1;
            end
            // two-pass division by a constant, omega on a period change, slew on resync
            S_QMUL1:
            begin
                cmd.op    = OP_QMUL1;
                unit_step = 1'b1;
                after     = S_RMUL1;
            end
            S_RMUL1:
            begin
                cmd.op    = OP_RMUL1;
                unit_step = 1'b1;
                after     = S_QMUL2;
            end
            S_QMUL2:
            begin
                cmd.op    = OP_QMUL2;
                unit_step = 1'b1;
                after     = S_RMUL2;
            end
            S_RMUL2:
            begin
                cmd.op    = OP_RMUL2;
                unit_step = 1'b1;
                after     = status.chg_flag ? S_BMUL : S_PDIV;
            end
            S_BMUL:
            begin
                cmd.op    = OP_BMUL;
                unit_step = 1'b1;
                after     = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.op    = status.chg_flag ? OP_CMUL : OP_CEMUL;
                unit_step = 1'b1;
                after     = S_OUT;
            end
            S_BEMUL:
            begin
                cmd.op    = OP_BEMUL;
                unit_step = 1'b1;
                after     = S_XUPD;
            end
            S_XUPD:
            begin
                // tracking path reuses the gain-c step for the period update
                cmd.op     = OP_XUPD;
                cmd.wb     = 1'b1;
                state_next = S_CMUL;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                launched_next = 1'b0;
            end
        endcase

        // launch the shared unit once, write back when it finishes
        if (unit_step)
        begin
            if (!launched_reg)
            begin
                cmd.start     = 1'b1;
                launched_next = 1'b1;
            end
            else if (status.unit_done)
            begin
                cmd.wb        = 1'b1;
                launched_next = 1'b0;
                state_next    = after;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end
endmodule

### rtl/audio_clock_dll_tracker_core.sv
// tracking request (same frame count, small error): two multiplies, no divide
// resync (error of 0.2 s or more): one divide and four multiplies
// frame count change: one divide and seven multiplies
// one request at a time; a held result delays the next accept
// reset clears the loop state, sample rate returns to 48000, no result pending
`include "audio_clock_dll_tracker_core_defines.svh"

module audio_clock_dll_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [17:0] cfg_wdata,
    adtr_req_if.sink    req,
    adtr_rsp_if.source  rsp
);
    import adtr_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencing
    adtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    adtr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_now      (req.now_ns),
        .in_frames   (req.frames),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_time    (rsp.next_time_ns),
        .out_pos     (rsp.next_position),
        .out_period  (rsp.period_frames_out),
        .out_slew    (rsp.slew_frames),
        .out_resync  (rsp.resynced),
        .out_changed (rsp.period_changed)
    );

    // checks
    `ADTR_ASSERT_NXT(busy_after_req, req.valid && req.ready && (req.frames != 13'd0), !req.ready, "request taken while busy")
    `ADTR_ASSERT_IMP(period_tracked, rsp.valid, rsp.period_frames_out != 13'd0, "result with no tracked period")
    `ADTR_ASSERT_IMP(one_branch, rsp.valid, !(rsp.resynced && rsp.period_changed), "resync and period change together")
    `ADTR_ASSERT_IMP(slew_only_resync, rsp.valid && !rsp.resynced, rsp.slew_frames == 32'sd0, "slew without resync")
endmodule
